>>> design/lcl_pkg.sv
`default_nettype none
package lcl_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_BITS = 16;
    localparam int COEF_W = 32;
    localparam int PROD_W = 64;
    localparam int QUOT_W = 49;
    localparam int CFG_IDX_W = 3;
    localparam int PHASE_W = 2;
    localparam int CS_W = 5;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [COEF_W-1:0] coef_t;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_L1 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_L2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RES_C = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RES_L1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RES_L2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RES_PRE = 3'd6;

    // Register reset values.
    localparam coef_t RST_GAIN_L1 = 32'd1717987;
    localparam coef_t RST_GAIN_L2 = 32'd8589935;
    localparam coef_t RST_GAIN_C = 32'd17179869;
    localparam coef_t RST_RES_C = 32'd32768;
    localparam coef_t RST_RES_L1 = 32'd655;
    localparam coef_t RST_RES_L2 = 32'd655;
    localparam coef_t RST_RES_PRE = 32'd720896;

    // Smoothing weights in Q0.32 and the fixed resistances in Q16.16.
    localparam coef_t WEIGHT_SMALL = 32'd42949673;
    localparam coef_t WEIGHT_LARGE = 32'd4252017623;
    localparam coef_t OPEN_OHMS = 32'd327680000;
    localparam coef_t SMOOTH_OHMS = 32'd786432;
    localparam logic [CS_W-1:0] CS_OPEN_MAX = 5'd4;
    localparam logic [CS_W-1:0] CS_PRELOAD = 5'd5;
    localparam logic [PHASE_W-1:0] LAST_PHASE = 2'd2;

    localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Multiply operations issued per phase.
    typedef enum logic [2:0] {
        OP_DROP1 = 3'd0,
        OP_DROP2 = 3'd1,
        OP_D1 = 3'd2,
        OP_D2 = 3'd3,
        OP_DC = 3'd4,
        OP_VR = 3'd5,
        OP_WS = 3'd6,
        OP_WL = 3'd7
    } op_t;

    typedef struct packed {
        logic capture;
        logic load;
        logic mul;
        logic store;
        logic commit;
        logic publish;
        op_t op;
        logic [PHASE_W-1:0] phase;
    } cmd_t;

    typedef struct packed {
        logic smooth;
    } status_t;

    function automatic data_t sat_add(input data_t a, input data_t b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1])
            return s[DATA_W] ? DATA_MIN : DATA_MAX;
        return s[DATA_W-1:0];
    endfunction

    function automatic data_t sat_sub(input data_t a, input data_t b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1])
            return s[DATA_W] ? DATA_MIN : DATA_MAX;
        return s[DATA_W-1:0];
    endfunction

    // Round the magnitude half away from zero, restore the sign, saturate.
    function automatic data_t round_sat(input logic [PROD_W-1:0] prod, input logic neg,
                                        input logic by_frac);
        logic [PROD_W:0] r;
        logic [QUOT_W-1:0] q;
        logic big;
        if (by_frac)
        begin
            r = {1'b0, prod} + (65'd1 << (FRAC_BITS - 1));
            q = r[PROD_W:FRAC_BITS];
        end
        else
        begin
            r = {1'b0, prod} + (65'd1 << (COEF_W - 1));
            q = {{(QUOT_W-(PROD_W+1-COEF_W)){1'b0}}, r[PROD_W:COEF_W]};
        end
        big = |q[QUOT_W-1:DATA_W-1];
        if (neg)
            return big ? DATA_MIN : data_t'(-q[DATA_W-1:0]);
        return big ? DATA_MAX : data_t'(q[DATA_W-1:0]);
    endfunction

endpackage
`default_nettype wire

>>> design/lcl_ctrl.sv
`default_nettype none
module lcl_ctrl
    import lcl_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input wire logic out_stall,
    input wire status_t status,
    output cmd_t cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOAD = 6'b000010,
        S_MUL = 6'b000100,
        S_STORE = 6'b001000,
        S_COMMIT = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    op_t op_reg, op_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free = !out_valid_reg || !out_stall;

    // Commands to the datapath.
    always_comb
    begin
        cmd.capture = (state_reg == S_IDLE) && in_valid;
        cmd.load = (state_reg == S_LOAD);
        cmd.mul = (state_reg == S_MUL);
        cmd.store = (state_reg == S_STORE);
        cmd.commit = (state_reg == S_COMMIT);
        cmd.publish = (state_reg == S_FINISH) && out_free;
        cmd.op = op_reg;
        cmd.phase = phase_reg;
    end

    // Sequencer over phases and multiply operations.
    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        phase_next = phase_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_LOAD;
                    op_next = OP_DROP1;
                    phase_next = '0;
                end
            end
            S_LOAD: state_next = S_MUL;
            S_MUL: state_next = S_STORE;
            S_STORE:
            begin
                state_next = S_LOAD;
                case (op_reg)
                    OP_DROP1: op_next = OP_DROP2;
                    OP_DROP2: op_next = OP_D1;
                    OP_D1: op_next = OP_D2;
                    OP_D2: op_next = OP_DC;
                    OP_DC: op_next = OP_VR;
                    OP_VR: state_next = S_COMMIT;
                    OP_WS: op_next = OP_WL;
                    default:
                    begin
                        op_next = OP_DROP1;
                        if (phase_reg == LAST_PHASE)
                            state_next = S_FINISH;
                        else
                            phase_next = phase_reg + 2'd1;
                    end
                endcase
            end
            S_COMMIT:
            begin
                state_next = S_LOAD;
                if (status.smooth)
                    op_next = OP_WS;
                else
                begin
                    op_next = OP_DROP1;
                    if (phase_reg == LAST_PHASE)
                        state_next = S_FINISH;
                    else
                        phase_next = phase_reg + 2'd1;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Result beat valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (cmd.publish)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg <= OP_DROP1;
            phase_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
            phase_reg <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

>>> design/lcl_datapath.sv
`default_nettype none
module lcl_datapath
    import lcl_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire cmd_t cmd,
    output status_t status,
    input wire logic cfg_write,
    input wire logic [CFG_IDX_W-1:0] cfg_index,
    input wire logic [COEF_W-1:0] cfg_data,
    input wire data_t conv_volt_a,
    input wire data_t conv_volt_b,
    input wire data_t conv_volt_c,
    input wire data_t grid_volt_a,
    input wire data_t grid_volt_b,
    input wire data_t grid_volt_c,
    input wire data_t neutral_volt,
    input wire logic signed [CS_W-1:0] contactor_state,
    output data_t conv_current_a,
    output data_t conv_current_b,
    output data_t conv_current_c,
    output data_t grid_current_a,
    output data_t grid_current_b,
    output data_t grid_current_c,
    output data_t mid_volt_a,
    output data_t mid_volt_b,
    output data_t mid_volt_c
);

    coef_t gain_l1_reg, gain_l2_reg, gain_c_reg, res_c_reg, res_l1_reg, res_l2_reg, res_pre_reg;

    // Filter state per phase.
    data_t i1_reg [3];
    data_t i2_reg [3];
    data_t vc_reg [3];
    data_t vp_reg [3];
    data_t gs_reg [3];

    // Captured input beat.
    data_t v1_reg [3];
    data_t v2_reg [3];
    data_t vn_reg;
    coef_t r2_reg;
    logic smooth_reg;

    // Per-phase intermediate terms.
    data_t drop1_reg, drop2_reg, d1_reg, d2_reg, dc_reg, vr_reg;

    // Shared multiplier pipeline.
    logic [DATA_W-1:0] mag_reg;
    logic neg_reg;
    coef_t coef_reg;
    logic by_frac_reg;
    logic [PROD_W-1:0] prod_reg;

    // Working results and published results.
    data_t conv_w_reg [3];
    data_t grid_w_reg [3];
    data_t mid_w_reg [3];
    data_t conv_o_reg [3];
    data_t grid_o_reg [3];
    data_t mid_o_reg [3];

    coef_t r2_sel;
    logic [CS_W-1:0] cs_bits;
    data_t opa;
    coef_t opb;
    logic op_frac;
    data_t res;
    data_t i1_p, i2_p, vc_p, vp_p, ic_p;
    data_t vp_new, i1_new, i2_new, vc_new, i2_smooth;

    assign status.smooth = smooth_reg;

    // Grid side resistance from the contactor state.
    always_comb
    begin
        cs_bits = contactor_state;
        if (cs_bits <= CS_OPEN_MAX)
            r2_sel = OPEN_OHMS;
        else if (cs_bits == CS_PRELOAD)
            r2_sel = res_pre_reg;
        else
            r2_sel = res_l2_reg;
    end

    // Operand selection for the multiplier.
    always_comb
    begin
        i1_p = i1_reg[cmd.phase];
        i2_p = i2_reg[cmd.phase];
        vc_p = vc_reg[cmd.phase];
        vp_p = vp_reg[cmd.phase];
        ic_p = sat_sub(i1_p, i2_p);
        opa = i1_p;
        opb = res_l1_reg;
        op_frac = 1'b1;
        case (cmd.op)
            OP_DROP1:
            begin
                opa = i1_p;
                opb = res_l1_reg;
            end
            OP_DROP2:
            begin
                opa = i2_p;
                opb = r2_reg;
            end
            OP_D1:
            begin
                opa = sat_sub(sat_sub(v1_reg[cmd.phase], vp_p), drop1_reg);
                opb = gain_l1_reg;
                op_frac = 1'b0;
            end
            OP_D2:
            begin
                opa = sat_sub(sat_sub(vp_p, sat_add(v2_reg[cmd.phase], vn_reg)), drop2_reg);
                opb = gain_l2_reg;
                op_frac = 1'b0;
            end
            OP_DC:
            begin
                opa = ic_p;
                opb = gain_c_reg;
                op_frac = 1'b0;
            end
            OP_VR:
            begin
                opa = ic_p;
                opb = res_c_reg;
            end
            OP_WS:
            begin
                opa = i2_p;
                opb = WEIGHT_SMALL;
                op_frac = 1'b0;
            end
            OP_WL:
            begin
                opa = i2_p;
                opb = WEIGHT_LARGE;
                op_frac = 1'b0;
            end
            default:
            begin
                opa = i1_p;
                opb = res_l1_reg;
            end
        endcase
    end

    // Rounded product and the state update of one phase.
    always_comb
    begin
        res = round_sat(prod_reg, neg_reg, by_frac_reg);
        vp_new = sat_add(sat_add(vr_reg, vc_p), vn_reg);
        i1_new = sat_add(i1_p, d1_reg);
        i2_new = sat_add(i2_p, d2_reg);
        vc_new = sat_add(vc_p, dc_reg);
        i2_smooth = sat_add(res, gs_reg[cmd.phase]);
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_l1_reg <= RST_GAIN_L1;
            gain_l2_reg <= RST_GAIN_L2;
            gain_c_reg <= RST_GAIN_C;
            res_c_reg <= RST_RES_C;
            res_l1_reg <= RST_RES_L1;
            res_l2_reg <= RST_RES_L2;
            res_pre_reg <= RST_RES_PRE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_GAIN_L1: gain_l1_reg <= cfg_data;
                REG_GAIN_L2: gain_l2_reg <= cfg_data;
                REG_GAIN_C: gain_c_reg <= cfg_data;
                REG_RES_C: res_c_reg <= cfg_data;
                REG_RES_L1: res_l1_reg <= cfg_data;
                REG_RES_L2: res_l2_reg <= cfg_data;
                REG_RES_PRE: res_pre_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Filter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                i1_reg[k] <= '0;
                i2_reg[k] <= '0;
                vc_reg[k] <= '0;
                vp_reg[k] <= '0;
                gs_reg[k] <= '0;
            end
        end
        else
        begin
            if (cmd.commit)
            begin
                vp_reg[cmd.phase] <= vp_new;
                i1_reg[cmd.phase] <= i1_new;
                i2_reg[cmd.phase] <= i2_new;
                vc_reg[cmd.phase] <= vc_new;
            end
            if (cmd.store && cmd.op == OP_WS)
                i2_reg[cmd.phase] <= i2_smooth;
            if (cmd.store && cmd.op == OP_WL)
                gs_reg[cmd.phase] <= res;
        end
    end

    // Input capture, multiplier pipeline and intermediate terms.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            v1_reg[0] <= conv_volt_a;
            v1_reg[1] <= conv_volt_b;
            v1_reg[2] <= conv_volt_c;
            v2_reg[0] <= grid_volt_a;
            v2_reg[1] <= grid_volt_b;
            v2_reg[2] <= grid_volt_c;
            vn_reg <= neutral_volt;
            r2_reg <= r2_sel;
            smooth_reg <= (r2_sel > SMOOTH_OHMS);
        end
        if (cmd.load)
        begin
            neg_reg <= opa[DATA_W-1];
            mag_reg <= opa[DATA_W-1] ? (~opa + 1'b1) : opa;
            coef_reg <= opb;
            by_frac_reg <= op_frac;
        end
        if (cmd.mul)
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(coef_reg);
        if (cmd.store)
        begin
            case (cmd.op)
                OP_DROP1: drop1_reg <= res;
                OP_DROP2: drop2_reg <= res;
                OP_D1: d1_reg <= res;
                OP_D2: d2_reg <= res;
                OP_DC: dc_reg <= res;
                OP_VR: vr_reg <= res;
                OP_WS: grid_w_reg[cmd.phase] <= i2_smooth;
                default: ;
            endcase
        end
        if (cmd.commit)
        begin
            conv_w_reg[cmd.phase] <= i1_new;
            grid_w_reg[cmd.phase] <= i2_new;
            mid_w_reg[cmd.phase] <= sat_sub(vp_new, vn_reg);
        end
        if (cmd.publish)
        begin
            for (int k = 0; k < 3; k++)
            begin
                conv_o_reg[k] <= conv_w_reg[k];
                grid_o_reg[k] <= grid_w_reg[k];
                mid_o_reg[k] <= mid_w_reg[k];
            end
        end
    end

    assign conv_current_a = conv_o_reg[0];
    assign conv_current_b = conv_o_reg[1];
    assign conv_current_c = conv_o_reg[2];
    assign grid_current_a = grid_o_reg[0];
    assign grid_current_b = grid_o_reg[1];
    assign grid_current_c = grid_o_reg[2];
    assign mid_volt_a = mid_o_reg[0];
    assign mid_volt_b = mid_o_reg[1];
    assign mid_volt_c = mid_o_reg[2];

endmodule
`default_nettype wire

>>> design/three_phase_lcl_filter_euler_step.sv
`default_nettype none
// One forward Euler step of a three-phase LCL filter per input beat. The three phases
// go one after another through a single 32x32 multiplier, and each multiply passes
// through operand select, multiply, and round and saturate in turn. A phase needs six
// multiplies plus one update step, and two more multiplies when grid current smoothing
// is on. A final step hands the result to the output register, and waits while an
// earlier result is still held there. The next input beat is taken while the previous
// result still waits at the output. Configuration writes are always ready and must only
// be made while the block is idle.
module three_phase_lcl_filter_euler_step
    import lcl_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic cfg_valid,
    output logic cfg_ready,
    input wire logic [CFG_IDX_W-1:0] cfg_index,
    input wire logic [COEF_W-1:0] cfg_data,
    input wire logic in_valid,
    output logic in_stall,
    input wire data_t conv_volt_a,
    input wire data_t conv_volt_b,
    input wire data_t conv_volt_c,
    input wire data_t grid_volt_a,
    input wire data_t grid_volt_b,
    input wire data_t grid_volt_c,
    input wire data_t neutral_volt,
    input wire logic signed [CS_W-1:0] contactor_state,
    output logic out_valid,
    input wire logic out_stall,
    output data_t conv_current_a,
    output data_t conv_current_b,
    output data_t conv_current_c,
    output data_t grid_current_a,
    output data_t grid_current_b,
    output data_t grid_current_c,
    output data_t mid_volt_a,
    output data_t mid_volt_b,
    output data_t mid_volt_c
);

    cmd_t cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    lcl_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .cmd(cmd)
    );

    lcl_datapath u_datapath (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .status(status),
        .cfg_write(cfg_valid && cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .conv_volt_a(conv_volt_a),
        .conv_volt_b(conv_volt_b),
        .conv_volt_c(conv_volt_c),
        .grid_volt_a(grid_volt_a),
        .grid_volt_b(grid_volt_b),
        .grid_volt_c(grid_volt_c),
        .neutral_volt(neutral_volt),
        .contactor_state(contactor_state),
        .conv_current_a(conv_current_a),
        .conv_current_b(conv_current_b),
        .conv_current_c(conv_current_c),
        .grid_current_a(grid_current_a),
        .grid_current_b(grid_current_b),
        .grid_current_c(grid_current_c),
        .mid_volt_a(mid_volt_a),
        .mid_volt_b(mid_volt_b),
        .mid_volt_c(mid_volt_c)
    );

endmodule
`default_nettype wire
